>>> rtl/aar_pkg.sv
// aar_pkg: shared types, constants and the cordic arctangent table for the
// axis-angle rotation matrix block; no dependencies
`default_nettype none

package aar_pkg;

   // angle units of 1/64 degree
   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
   localparam logic signed [19:0] DEG64_TO_Q30 = 20'sd292818;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ROUND_Q16       = 34'sd8192;
   localparam logic signed [17:0] ONE_Q16         = 18'sd65536;
   localparam logic signed [15:0] ONE_Q14         = 16'sd16384;
   localparam logic signed [51:0] ROUND_Q48       = 52'sd8589934592;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int SQRT_STEPS       = 30;
   localparam int DIV_STEPS        = 17;

   // squares, sum, root steps, divider set-up, divider steps, clamp
   localparam int NORM_LAT = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   // queue, capture, normalise, three matrix stages
   localparam int RSP_LAT  = 1 + 1 + NORM_LAT + 3;

   typedef logic [2:0][15:0] aar_vec_type;

   typedef struct packed {
      logic               zero;
      logic               neg_cos;
      logic signed [33:0] z;
      aar_vec_type        axis;
   } aar_item_type;

   typedef struct packed {
      logic [8:0][15:0] entry;
      logic             zero;
   } aar_result_type;

   function automatic logic [29:0] atan_q30(input int unsigned idx);
      logic [29:0] val;
      case (idx)
         0:       val = 30'd843314856;
         1:       val = 30'd497837829;
         2:       val = 30'd263043836;
         3:       val = 30'd133525158;
         4:       val = 30'd67021686;
         5:       val = 30'd33543515;
         6:       val = 30'd16775850;
         7:       val = 30'd8388437;
         8:       val = 30'd4194282;
         9:       val = 30'd2097149;
         10:      val = 30'd1048575;
         11:      val = 30'd524287;
         12:      val = 30'd262143;
         13:      val = 30'd131071;
         14:      val = 30'd65535;
         15:      val = 30'd32767;
         16:      val = 30'd16383;
         17:      val = 30'd8191;
         18:      val = 30'd4095;
         19:      val = 30'd2047;
         20:      val = 30'd1023;
         21:      val = 30'd511;
         22:      val = 30'd255;
         23:      val = 30'd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/aar_front.sv
// aar_front: takes a word on start, reduces the angle, flags a zero axis
// depends on aar_pkg
`default_nettype none

module aar_front (
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  queue_full,
   input  wire logic signed [15:0]    angle_deg,
   input  wire logic signed [15:0]    axis_x,
   input  wire logic signed [15:0]    axis_y,
   input  wire logic signed [15:0]    axis_z,
   output logic                       busy,
   output logic                       push,
   output aar_pkg::aar_item_type      item
);

   logic signed [16:0] ang_ext;
   logic signed [16:0] wrapped;
   logic signed [16:0] folded;
   logic               neg_cos;
   logic signed [13:0] ang_red;
   logic signed [33:0] z_q30;

   assign busy = reset | queue_full;
   assign push = start & ~busy;

   always_comb begin
      ang_ext = {angle_deg[15], angle_deg};
      // one wrap brings any 16-bit angle into half-open half turn
      if (ang_ext >= aar_pkg::HALF_TURN) begin
         wrapped = ang_ext - aar_pkg::FULL_TURN;
      end else if (ang_ext < -aar_pkg::HALF_TURN) begin
         wrapped = ang_ext + aar_pkg::FULL_TURN;
      end else begin
         wrapped = ang_ext;
      end
      // fold into a quarter turn, cosine flips sign
      neg_cos = 1'b0;
      if (wrapped > aar_pkg::QUARTER_TURN) begin
         folded  = aar_pkg::HALF_TURN - wrapped;
         neg_cos = 1'b1;
      end else if (wrapped < -aar_pkg::QUARTER_TURN) begin
         folded  = -aar_pkg::HALF_TURN - wrapped;
         neg_cos = 1'b1;
      end else begin
         folded = wrapped;
      end
      ang_red = folded[13:0];
      z_q30   = ang_red * aar_pkg::DEG64_TO_Q30;
   end

   always_comb begin
      item.zero    = (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
      item.neg_cos = neg_cos;
      item.z       = z_q30;
      item.axis    = {axis_z, axis_y, axis_x};
   end

endmodule

`default_nettype wire

>>> rtl/aar_queue.sv
// aar_queue: two-word queue between front and back, head read directly
// depends on aar_pkg
`default_nettype none

module aar_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire aar_pkg::aar_item_type push_item,
   output logic                       full,
   output logic                       head_valid,
   output aar_pkg::aar_item_type      head_item
);

   aar_pkg::aar_item_type mem_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   // the back end never stalls, so the head leaves as soon as it shows
   assign pop        = head_valid;
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_drains_each_cycle: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd1)
      else $error("queue holds more than one word");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !head_valid) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a word");

endmodule

`default_nettype wire

>>> rtl/aar_cordic.sv
// aar_cordic: rotation-mode cordic, one stage per step, then rounding to q16
// depends on aar_pkg
`default_nettype none

module aar_cordic #(
   parameter int CORDIC_STEPS = aar_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic signed [33:0] z_in,
   input  wire logic               neg_in,
   output logic signed [17:0]      cos_out,
   output logic signed [17:0]      sin_out
);

   localparam int STEPS = (CORDIC_STEPS < aar_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : aar_pkg::ATAN_ENTRIES;

   logic signed [33:0] x_ff   [STEPS];
   logic signed [33:0] y_ff   [STEPS];
   logic signed [33:0] z_ff   [STEPS];
   logic               neg_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [33:0] ATAN = {4'b0000, aar_pkg::atan_q30(i)};
      logic signed [33:0] x_prev, y_prev, z_prev;
      logic               neg_prev;
      logic signed [33:0] x_in, y_in, z_step_in;

      if (i == 0) begin : g_first
         assign x_prev   = aar_pkg::CORDIC_GAIN_Q30;
         assign y_prev   = '0;
         assign z_prev   = z_in;
         assign neg_prev = neg_in;
      end else begin : g_next
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      always_comb begin
         if (!z_prev[33]) begin
            x_in      = x_prev - (y_prev >>> i);
            y_in      = y_prev + (x_prev >>> i);
            z_step_in = z_prev - ATAN;
         end else begin
            x_in      = x_prev + (y_prev >>> i);
            y_in      = y_prev - (x_prev >>> i);
            z_step_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i]   <= x_in;
         y_ff[i]   <= y_in;
         z_ff[i]   <= z_step_in;
         neg_ff[i] <= neg_prev;
      end
   end

   function automatic logic signed [17:0] round_hold(input logic signed [33:0] v);
      logic signed [33:0] sum;
      logic signed [19:0] shr;
      logic signed [17:0] res;
      sum = v + aar_pkg::ROUND_Q16;
      shr = sum[33:14];
      if (shr > 20'sd65536) begin
         res = aar_pkg::ONE_Q16;
      end else if (shr < -20'sd65536) begin
         res = -aar_pkg::ONE_Q16;
      end else begin
         res = shr[17:0];
      end
      return res;
   endfunction

   logic signed [17:0] cos_rnd, sin_rnd;
   logic signed [17:0] cos_ff, cos_in;
   logic signed [17:0] sin_ff, sin_in;

   always_comb begin
      cos_rnd = round_hold(x_ff[STEPS-1]);
      sin_rnd = round_hold(y_ff[STEPS-1]);
      cos_in  = neg_ff[STEPS-1] ? -cos_rnd : cos_rnd;
      sin_in  = sin_rnd;
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

>>> rtl/aar_norm.sv
// aar_norm: axis to unit length, pipelined square root then three dividers
// depends on aar_pkg
`default_nettype none

module aar_norm (
   input  wire logic                 clock,
   input  wire aar_pkg::aar_vec_type axis_in,
   output logic [2:0][17:0]          unit_out
);

   localparam int SQ = aar_pkg::SQRT_STEPS;
   localparam int DV = aar_pkg::DIV_STEPS;

   // squares and their sum
   logic signed [31:0]   prod [3];
   logic [30:0]          sq_ff [3];
   aar_pkg::aar_vec_type v1_ff, v2_ff;
   logic [31:0]          q_ff, q_in;

   for (genvar c = 0; c < 3; c++) begin : g_sq
      assign prod[c] = $signed(axis_in[c]) * $signed(axis_in[c]);
   end

   assign q_in = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]};

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         sq_ff[c] <= prod[c][30:0];
      end
      v1_ff <= axis_in;
      q_ff  <= q_in;
      v2_ff <= v1_ff;
   end

   // digit-by-digit root of q * 2^28, one result bit a stage
   logic [59:0]          n_ff    [SQ];
   logic [29:0]          root_ff [SQ];
   logic [31:0]          rem_ff  [SQ];
   aar_pkg::aar_vec_type vs_ff   [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_root
      logic [59:0]          n_prev;
      logic [29:0]          root_prev;
      logic [31:0]          rem_prev;
      aar_pkg::aar_vec_type v_prev;
      logic [33:0]          rem_sh, trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign n_prev    = {q_ff, 28'd0};
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign v_prev    = v2_ff;
      end else begin : g_next
         assign n_prev    = n_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign v_prev    = vs_ff[k-1];
      end

      assign rem_sh = {rem_prev, n_prev[59:58]};
      assign trial  = {2'b00, root_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         n_ff[k]    <= {n_prev[57:0], 2'b00};
         root_ff[k] <= {root_prev[28:0], ge};
         rem_ff[k]  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
         vs_ff[k]   <= v_prev;
      end
   end

   // restoring dividers, index 0 is the set-up stage
   logic [29:0] len_ff [DV+1];
   logic [29:0] drem_ff [DV+1][3];
   logic [16:0] nb_ff   [DV+1][3];
   logic [16:0] quo_ff  [DV+1][3];
   logic        sgn_ff  [DV+1][3];
   logic [17:0] unit_ff [3];

   always_ff @(posedge clock) begin
      len_ff[0] <= root_ff[SQ-1];
      for (int j = 1; j <= DV; j++) begin
         len_ff[j] <= len_ff[j-1];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_comp
      logic signed [16:0] v_ext;
      logic [16:0]        mag17;
      logic [45:0]        numer;

      assign v_ext = {vs_ff[SQ-1][c][15], vs_ff[SQ-1][c]};
      assign mag17 = v_ext[16] ? 17'(-v_ext) : 17'(v_ext);
      // magnitude never exceeds len / 2^14, so the quotient fits 17 bits
      assign numer = {mag17[15:0], 30'd0} + {17'd0, root_ff[SQ-1][29:1]};

      always_ff @(posedge clock) begin
         drem_ff[0][c] <= {1'b0, numer[45:17]};
         nb_ff[0][c]   <= numer[16:0];
         quo_ff[0][c]  <= '0;
         sgn_ff[0][c]  <= v_ext[16];
      end

      for (genvar j = 0; j < DV; j++) begin : g_div
         logic [30:0] rem_sh;
         logic        ge;

         assign rem_sh = {drem_ff[j][c], nb_ff[j][c][16]};
         assign ge     = (rem_sh >= {1'b0, len_ff[j]});

         always_ff @(posedge clock) begin
            drem_ff[j+1][c] <= ge ? 30'(rem_sh - {1'b0, len_ff[j]}) : rem_sh[29:0];
            nb_ff[j+1][c]   <= {nb_ff[j][c][15:0], 1'b0};
            quo_ff[j+1][c]  <= {quo_ff[j][c][15:0], ge};
            sgn_ff[j+1][c]  <= sgn_ff[j][c];
         end
      end

      logic [17:0] clamped;
      assign clamped = (quo_ff[DV][c] > 17'd65536) ? 18'd65536 : {1'b0, quo_ff[DV][c]};

      always_ff @(posedge clock) begin
         unit_ff[c] <= sgn_ff[DV][c] ? 18'(-clamped) : clamped;
      end

      assign unit_out[c] = unit_ff[c];
   end

endmodule

`default_nettype wire

>>> rtl/aar_back.sv
// aar_back: sine and cosine, unit axis, and the rodrigues products
// depends on aar_pkg, aar_cordic, aar_norm
`default_nettype none

module aar_back #(
   parameter int CORDIC_STEPS = aar_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire aar_pkg::aar_item_type head_item,
   output logic                       rsp_valid,
   output aar_pkg::aar_result_type    result
);

   localparam int STEPS  = (CORDIC_STEPS < aar_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : aar_pkg::ATAN_ENTRIES;
   localparam int NL     = aar_pkg::NORM_LAT;
   localparam int CS_DLY = NL - 1 - STEPS;

   // capture from the queue head
   aar_pkg::aar_item_type item_ff;
   logic                  s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= head_item;
   end

   logic signed [17:0] cos_raw, sin_raw;
   logic [2:0][17:0]   unit;

   aar_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .z_in    (item_ff.z),
      .neg_in  (item_ff.neg_cos),
      .cos_out (cos_raw),
      .sin_out (sin_raw)
   );

   aar_norm u_norm (
      .clock    (clock),
      .axis_in  (item_ff.axis),
      .unit_out (unit)
   );

   // line up sine and cosine with the unit axis
   logic [35:0] cs_ff [CS_DLY];

   always_ff @(posedge clock) begin
      cs_ff[0] <= {cos_raw, sin_raw};
      for (int k = 1; k < CS_DLY; k++) begin
         cs_ff[k] <= cs_ff[k-1];
      end
   end

   logic [NL-1:0] vld_line_ff;
   logic [NL-1:0] zero_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_line_ff <= '0;
      end else begin
         vld_line_ff <= {vld_line_ff[NL-2:0], s0_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      zero_line_ff <= {zero_line_ff[NL-2:0], item_ff.zero};
   end

   // first products: t * a and s * a
   logic signed [17:0] c_al, s_al;
   logic signed [18:0] t_q16;
   logic signed [36:0] ta_in [3];
   logic signed [35:0] sa_in [3];
   logic signed [36:0] ta_ff [3];
   logic signed [35:0] sa_ff [3];
   logic signed [17:0] c1_ff;
   logic [2:0][17:0]   a1_ff;
   logic               m1_valid_ff, m1_zero_ff;

   assign c_al  = $signed(cs_ff[CS_DLY-1][35:18]);
   assign s_al  = $signed(cs_ff[CS_DLY-1][17:0]);
   assign t_q16 = 19'sd65536 - {c_al[17], c_al};

   for (genvar k = 0; k < 3; k++) begin : g_m1
      assign ta_in[k] = t_q16 * $signed(unit[k]);
      assign sa_in[k] = s_al * $signed(unit[k]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ta_ff[k] <= ta_in[k];
         sa_ff[k] <= sa_in[k];
      end
      c1_ff      <= c_al;
      a1_ff      <= unit;
      m1_zero_ff <= zero_line_ff[NL-1];
   end

   // second products: t * a_i * a_j, all terms in q48
   logic signed [54:0] tp_in [6];
   logic signed [51:0] tp_ff [6];
   logic signed [51:0] sp_ff [3];
   logic signed [51:0] cc_ff;
   logic               m2_valid_ff, m2_zero_ff;

   assign tp_in[0] = ta_ff[0] * $signed(a1_ff[0]);
   assign tp_in[1] = ta_ff[1] * $signed(a1_ff[1]);
   assign tp_in[2] = ta_ff[2] * $signed(a1_ff[2]);
   assign tp_in[3] = ta_ff[0] * $signed(a1_ff[1]);
   assign tp_in[4] = ta_ff[0] * $signed(a1_ff[2]);
   assign tp_in[5] = ta_ff[1] * $signed(a1_ff[2]);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         tp_ff[k] <= tp_in[k][51:0];
      end
      for (int k = 0; k < 3; k++) begin
         sp_ff[k] <= {sa_ff[k], 16'd0};
      end
      cc_ff      <= {{2{c1_ff[17]}}, c1_ff, 32'd0};
      m2_zero_ff <= m1_zero_ff;
   end

   function automatic logic [15:0] to_q14(input logic signed [51:0] v);
      logic signed [51:0] sum;
      logic signed [17:0] shr;
      logic signed [15:0] res;
      sum = v + aar_pkg::ROUND_Q48;
      shr = sum[51:34];
      if (shr > 18'sd16384) begin
         res = aar_pkg::ONE_Q14;
      end else if (shr < -18'sd16384) begin
         res = -aar_pkg::ONE_Q14;
      end else begin
         res = shr[15:0];
      end
      return res;
   endfunction

   // sums, rounding and the identity for a zero axis
   aar_pkg::aar_result_type res_ff, res_in;
   logic                    res_valid_ff;

   always_comb begin
      res_in.zero = m2_zero_ff;
      if (m2_zero_ff) begin
         res_in.entry = '0;
         res_in.entry[0] = aar_pkg::ONE_Q14;
         res_in.entry[4] = aar_pkg::ONE_Q14;
         res_in.entry[8] = aar_pkg::ONE_Q14;
      end else begin
         res_in.entry[0] = to_q14(cc_ff + tp_ff[0]);
         res_in.entry[1] = to_q14(tp_ff[3] - sp_ff[2]);
         res_in.entry[2] = to_q14(tp_ff[4] + sp_ff[1]);
         res_in.entry[3] = to_q14(tp_ff[3] + sp_ff[2]);
         res_in.entry[4] = to_q14(cc_ff + tp_ff[1]);
         res_in.entry[5] = to_q14(tp_ff[5] - sp_ff[0]);
         res_in.entry[6] = to_q14(tp_ff[4] - sp_ff[1]);
         res_in.entry[7] = to_q14(tp_ff[5] + sp_ff[0]);
         res_in.entry[8] = to_q14(cc_ff + tp_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff  <= vld_line_ff[NL-1];
         m2_valid_ff  <= m1_valid_ff;
         res_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = res_valid_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

>>> rtl/axis_angle_rotation_matrix.sv
// axis_angle_rotation_matrix: top level, 3x3 rotation matrix from axis and angle
// depends on aar_pkg, aar_front, aar_queue, aar_back
//
//   channel   direction  handshake            word
//   req_      in         start high, busy low angle and three axis components
//   rsp_      out        rsp_valid strobe     nine q2.14 entries, zero-axis flag
//
// takes one word every clock outside reset; the delay from taking a word to its
// result is set by the 30-stage square root and the 17-stage divider that
// normalise the axis (the cordic runs alongside and is delayed to match)
// sync reset clears only valid flags and queue state; busy is high during reset
// the receiver cannot stall: the queue drains every cycle, so busy never rises
// outside reset
`default_nettype none

module axis_angle_rotation_matrix #(
   parameter int CORDIC_STEPS = aar_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_angle_deg,
   input  wire logic signed [15:0] req_axis_x,
   input  wire logic signed [15:0] req_axis_y,
   input  wire logic signed [15:0] req_axis_z,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_row0_col0,
   output logic signed [15:0]      rsp_row0_col1,
   output logic signed [15:0]      rsp_row0_col2,
   output logic signed [15:0]      rsp_row1_col0,
   output logic signed [15:0]      rsp_row1_col1,
   output logic signed [15:0]      rsp_row1_col2,
   output logic signed [15:0]      rsp_row2_col0,
   output logic signed [15:0]      rsp_row2_col1,
   output logic signed [15:0]      rsp_row2_col2,
   output logic                    rsp_axis_was_zero
);

   localparam int LAT = aar_pkg::RSP_LAT;

   logic                    push;
   logic                    queue_full;
   logic                    head_valid;
   aar_pkg::aar_item_type   push_item;
   aar_pkg::aar_item_type   head_item;
   aar_pkg::aar_result_type result;

   // front end: handshake, angle reduction, zero-axis check
   aar_front u_front (
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .angle_deg  (req_angle_deg),
      .axis_x     (req_axis_x),
      .axis_y     (req_axis_y),
      .axis_z     (req_axis_z),
      .busy       (busy),
      .push       (push),
      .item       (push_item)
   );

   // decouples the front from the back pipeline
   aar_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back end: cordic, normalisation and matrix products
   aar_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .rsp_valid  (rsp_valid),
      .result     (result)
   );

   // entries are packed row by row
   assign rsp_row0_col0     = $signed(result.entry[0]);
   assign rsp_row0_col1     = $signed(result.entry[1]);
   assign rsp_row0_col2     = $signed(result.entry[2]);
   assign rsp_row1_col0     = $signed(result.entry[3]);
   assign rsp_row1_col1     = $signed(result.entry[4]);
   assign rsp_row1_col2     = $signed(result.entry[5]);
   assign rsp_row2_col0     = $signed(result.entry[6]);
   assign rsp_row2_col1     = $signed(result.entry[7]);
   assign rsp_row2_col2     = $signed(result.entry[8]);
   assign rsp_axis_was_zero = result.zero;

   logic accepted;
   assign accepted = start & ~busy;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##LAT rsp_valid)
      else $error("accepted word gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accepted, LAT))
      else $error("result without an accepted word");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_axis_was_zero) |->
         (rsp_row1_col1 == aar_pkg::ONE_Q14) && (rsp_row0_col1 == 16'sd0))
      else $error("zero axis did not give identity");

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for axis_angle_rotation_matrix, directed table then random words
// depends on aar_pkg and the rtl top level; predicts each matrix with its own fixed-point model
`default_nettype none

module tb;

   localparam int STEPS     = aar_pkg::CORDIC_STEPS_DEF;
   localparam int N_RANDOM  = 1500;
   localparam int WDOG_MAX  = 2000;
   localparam int N_DIRECT  = 20;

   typedef struct {
      logic signed [15:0] entry [9];
      logic               zero;
   } matrix_word_type;

   // one row of the directed table; has_exp marks rows typed in by hand
   typedef struct {
      logic signed [15:0] ang, ax, ay, az;
      bit                 has_exp;
      matrix_word_type    exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_angle_deg = '0, req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_row0_col0, rsp_row0_col1, rsp_row0_col2;
   logic signed [15:0] rsp_row1_col0, rsp_row1_col1, rsp_row1_col2;
   logic signed [15:0] rsp_row2_col0, rsp_row2_col1, rsp_row2_col2;
   logic rsp_axis_was_zero;

   matrix_word_type pending_matrices[$];
   int  n_errors = 0;
   int  idle_cycles = 0;
   bit  stim_done = 1'b0;
   bit  quiet_phase = 1'b0;

   axis_angle_rotation_matrix #(.CORDIC_STEPS(STEPS)) DUT (
      .clock, .reset, .start, .busy,
      .req_angle_deg, .req_axis_x, .req_axis_y, .req_axis_z,
      .rsp_valid,
      .rsp_row0_col0, .rsp_row0_col1, .rsp_row0_col2,
      .rsp_row1_col0, .rsp_row1_col1, .rsp_row1_col2,
      .rsp_row2_col0, .rsp_row2_col1, .rsp_row2_col2,
      .rsp_axis_was_zero
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor shift right, arithmetic on signed 64-bit
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // normalised axis component in q16, magnitude held to one
   function automatic longint unit_q16(longint v, longint unsigned len);
      longint unsigned mag, q;
      mag = (v < 0) ? -v : v;
      q = ((mag << 30) + (len >> 1)) / len;
      if (q > 65536) q = 65536;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] q48_to_q14(longint v);
      return 16'(clamp_sym(floor_shr(v + (64'sd1 <<< 33), 34), 16384));
   endfunction

   // rodrigues matrix for one word
   function automatic matrix_word_type rotation_of(logic signed [15:0] ang16,
         logic signed [15:0] x16, logic signed [15:0] y16, logic signed [15:0] z16);
      matrix_word_type m;
      longint r, x, y, z, dx, dy, c, s, t, ax, ay, az, cc, sx, sy, sz;
      longint vx, vy, vz;
      longint unsigned q, len;
      bit neg_cos;
      vx = x16; vy = y16; vz = z16;
      m.zero = 1'b0;
      if (vx == 0 && vy == 0 && vz == 0) begin
         for (int k = 0; k < 9; k++)
            m.entry[k] = (k % 4 == 0) ? aar_pkg::ONE_Q14 : 16'sd0;
         m.zero = 1'b1;
         return m;
      end
      r = ((longint'(ang16) % 23040) + 23040) % 23040;
      neg_cos = 1'b0;
      if (r >= 11520) r -= 23040;
      if (r > 5760) begin
         r = 11520 - r;
         neg_cos = 1'b1;
      end else if (r < -5760) begin
         r = -11520 - r;
         neg_cos = 1'b1;
      end
      z = r * 292818;
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS && i < aar_pkg::ATAN_ENTRIES; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(aar_pkg::atan_q30(i));
         end else begin
            x += dx; y -= dy; z += longint'(aar_pkg::atan_q30(i));
         end
      end
      c = clamp_sym(floor_shr(x + 8192, 14), 65536);
      s = clamp_sym(floor_shr(y + 8192, 14), 65536);
      if (neg_cos) c = -c;
      t = 65536 - c;
      q = vx * vx + vy * vy + vz * vz;
      len = int_sqrt(q << 28);
      ax = unit_q16(vx, len);
      ay = unit_q16(vy, len);
      az = unit_q16(vz, len);
      cc = c * 64'sd4294967296;
      sx = s * ax * 65536; sy = s * ay * 65536; sz = s * az * 65536;
      m.entry[0] = q48_to_q14(cc + t * ax * ax);
      m.entry[1] = q48_to_q14(t * ax * ay - sz);
      m.entry[2] = q48_to_q14(t * ax * az + sy);
      m.entry[3] = q48_to_q14(t * ax * ay + sz);
      m.entry[4] = q48_to_q14(cc + t * ay * ay);
      m.entry[5] = q48_to_q14(t * ay * az - sx);
      m.entry[6] = q48_to_q14(t * ax * az - sy);
      m.entry[7] = q48_to_q14(t * ay * az + sx);
      m.entry[8] = q48_to_q14(cc + t * az * az);
      return m;
   endfunction

   function automatic matrix_word_type identity_word(bit zero);
      matrix_word_type m;
      for (int k = 0; k < 9; k++) m.entry[k] = (k % 4 == 0) ? aar_pkg::ONE_Q14 : 16'sd0;
      m.zero = zero;
      return m;
   endfunction

   stim_row_type direct_rows [N_DIRECT];

   initial begin
      // zero axis: identity with the flag, angle ignored
      direct_rows[0]  = '{16'sd0,      16'sd0,      16'sd0,      16'sd0,     1, identity_word(1)};
      direct_rows[1]  = '{16'sd23040,  16'sd0,      16'sd0,      16'sd0,     1, identity_word(1)};
      direct_rows[2]  = '{-16'sd32768, 16'sd0,      16'sd0,      16'sd0,     1, identity_word(1)};
      // zero angle or a full turn on a unit axis gives plain identity
      direct_rows[3]  = '{16'sd0,      16'sd16384,  16'sd0,      16'sd0,     1, identity_word(0)};
      direct_rows[4]  = '{16'sd23040,  16'sd0,      16'sd0,      -16'sd16384, 1, identity_word(0)};
      // the rest are predicted: quarter and half turns, wraps, extreme fields
      direct_rows[5]  = '{16'sd5760,   16'sd0,      16'sd0,      16'sd16384, 0, identity_word(0)};
      direct_rows[6]  = '{16'sd11520,  16'sd0,      16'sd16384,  16'sd0,     0, identity_word(0)};
      direct_rows[7]  = '{-16'sd11520, 16'sd16384,  16'sd16384,  16'sd16384, 0, identity_word(0)};
      direct_rows[8]  = '{-16'sd5760,  16'sd100,    -16'sd200,   16'sd300,   0, identity_word(0)};
      direct_rows[9]  = '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767, 0, identity_word(0)};
      direct_rows[10] = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, identity_word(0)};
      direct_rows[11] = '{16'sd23039,  16'sd1,      16'sd0,      16'sd0,     0, identity_word(0)};
      direct_rows[12] = '{-16'sd23040, 16'sd0,      -16'sd1,     16'sd0,     0, identity_word(0)};
      direct_rows[13] = '{16'sd5761,   16'sd0,      16'sd0,      16'sd1,     0, identity_word(0)};
      direct_rows[14] = '{-16'sd5761,  16'sd32767,  -16'sd32768, 16'sd1,     0, identity_word(0)};
      direct_rows[15] = '{16'sd1,      16'sd12345,  16'sd6789,   -16'sd4321, 0, identity_word(0)};
      direct_rows[16] = '{16'sd2880,   16'sd16384,  16'sd0,      16'sd0,     0, identity_word(0)};
      direct_rows[17] = '{16'sd17280,  16'sd0,      16'sd16384,  16'sd0,     0, identity_word(0)};
      direct_rows[18] = '{16'sd11519,  -16'sd1,     16'sd1,      -16'sd1,    0, identity_word(0)};
      direct_rows[19] = '{16'sh5555,   16'shAAAA,   16'sh5555,   16'shAAAA,  0, identity_word(0)};
   end

   // hold one word on the bus until it is taken
   task automatic send_word(logic signed [15:0] ang, logic signed [15:0] x,
         logic signed [15:0] y, logic signed [15:0] z, bit has_exp, matrix_word_type exp);
      req_angle_deg <= ang;
      req_axis_x <= x;
      req_axis_y <= y;
      req_axis_z <= z;
      start <= 1'b1;
      pending_matrices.push_back(has_exp ? exp : rotation_of(ang, x, y, z));
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_burst();
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_axis_comp(int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return 16'($signed($urandom_range(0, 400)) - 200);
         default: return ($urandom_range(0, 2) == 0) ? 16'sd0 : 16'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      logic signed [15:0] ang, x, y, z;
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (direct_rows[i]) begin
         send_word(direct_rows[i].ang, direct_rows[i].ax, direct_rows[i].ay,
                   direct_rows[i].az, direct_rows[i].has_exp, direct_rows[i].exp);
         idle_burst();
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         // last stretch of the run goes back to back
         if (n > N_RANDOM - 200) quiet_phase = 1'b1;
         // mostly in-range angles, some anywhere in the 16-bit field
         ang = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, 46080)) - 23040);
         mode = $urandom_range(0, 2);
         x = rand_axis_comp(mode);
         y = rand_axis_comp(mode);
         z = rand_axis_comp(mode);
         if ($urandom_range(0, 49) == 0) begin
            x = 0; y = 0; z = 0;
         end
         send_word(ang, x, y, z, 1'b0, identity_word(0));
         idle_burst();
      end
      start <= 1'b0;
      stim_done = 1'b1;
   end

   // result checker: one word per strobe, compared to the oldest prediction
   always @(posedge clock) begin
      logic signed [15:0] got [9];
      matrix_word_type exp;
      if (!reset && rsp_valid) begin
         got = '{rsp_row0_col0, rsp_row0_col1, rsp_row0_col2,
                 rsp_row1_col0, rsp_row1_col1, rsp_row1_col2,
                 rsp_row2_col0, rsp_row2_col1, rsp_row2_col2};
         if (pending_matrices.size() == 0) begin
            $display("%0t: unexpected result word", $time);
            n_errors++;
         end else begin
            exp = pending_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== exp.entry[k]) begin
                  $display("%0t: entry %0d%0d expected %0d actual %0d", $time,
                           k / 3, k % 3, exp.entry[k], got[k]);
                  n_errors++;
               end
            if (rsp_axis_was_zero !== exp.zero) begin
               $display("%0t: axis_was_zero expected %0b actual %0b", $time,
                        exp.zero, rsp_axis_was_zero);
               n_errors++;
            end
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a result out
   always @(posedge clock) begin
      if ((start && !busy && !reset) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // end of run: drain, then a settling margin beyond the full response latency
   initial begin
      wait (stim_done);
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (aar_pkg::RSP_LAT + 8) @(posedge clock);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
